/* src/fcc_pkg.sv */
// ----------------------------------------------------------------------------
// FAT12 cluster chain sequencer package
// Shared constants, action and register codes, and the table write beat type.
// ----------------------------------------------------------------------------
`default_nettype none

package fcc_pkg;

    localparam int TABLE_BYTES_DEF = 8192;

    // Cluster numbers at or above this value mark the end of a chain.
    localparam logic [11:0] END_MARK = 12'hFF8;
    localparam logic [7:0]  MAX_SPC  = 8'd128;
    // Cluster 2 is the first cluster of the data area.
    localparam logic [12:0] FIRST_DATA_CLUSTER = 13'd2;

    localparam logic [7:0]  SPC_RESET        = 8'd1;
    localparam logic [31:0] DATA_START_RESET = 32'd33;

    typedef enum logic [1:0] {
        ACT_LOAD       = 2'd0,
        ACT_OPEN_CHAIN = 2'd1,
        ACT_OPEN_ROOT  = 2'd2,
        ACT_ADVANCE    = 2'd3
    } action_t;

    typedef enum logic {
        CFG_SPC        = 1'b0,
        CFG_DATA_START = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic        en;
        logic [12:0] index;
        logic [7:0]  data;
    } fcc_wr_t;

endpackage

`default_nettype wire

/* src/fat12_cluster_chain_sequencer.sv */
// ----------------------------------------------------------------------------
// FAT12 cluster chain sequencer
// Walks a FAT12 cluster chain or a flat root directory, one sector per beat.
// ----------------------------------------------------------------------------
// Input beats arrive on the s_ channel: s_tuser carries the action (load a
// table byte, open a chain, open the root directory, advance one sector) and
// s_tdata carries its operands. Every input beat yields exactly one output
// beat on the m_ channel with the block address, the current cluster and the
// end-of-chain flag as they stand after the action.
// From acceptance an item passes through S_SCALE and S_EMIT to the output
// register; an advance that leaves a cluster passes through S_LOOKUP first,
// for the registered read of the allocation table banks. The next item can be
// taken in the cycle after the previous result is loaded into the output
// register; no new item is taken before then. The address scale (cluster
// offset times sectors per cluster) and the final add sit in S_SCALE and S_EMIT.
// The output register lets a new item start while a result waits; a stalled
// receiver holds the finished result in the last step and blocks further input.
// Reset returns the position state to chain mode at cluster zero and the
// configuration to its defaults; the table content is undefined until loaded.
// Configuration writes on the cfg_ channel are always taken and must be made
// while no item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module fat12_cluster_chain_sequencer
    import fcc_pkg::*;
#(
    parameter int TABLE_BYTES = TABLE_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    // table_byte_index[12:0], table_byte[20:13], first_cluster[32:21],
    // root_start_lba[64:33], zero padding[71:65]
    input  logic [71:0] s_tdata,
    // action[1:0]
    input  logic [1:0]  s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // sector_lba[31:0], cluster_now[43:32], zero padding[47:44]
    output logic [47:0] m_tdata,
    // end_of_chain[0]
    output logic [0:0]  m_tuser,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_SCALE,
        S_EMIT
    } state_t;

    state_t             state_reg,       state_next;
    logic [11:0]        cluster_reg,     cluster_next;
    logic [6:0]         sic_reg,         sic_next;
    logic [31:0]        root_block_reg,  root_block_next;
    logic               root_mode_reg,   root_mode_next;
    logic               ended_reg,       ended_next;
    logic signed [21:0] product_reg,     product_next;
    logic [31:0]        base_reg,        base_next;
    logic               out_valid_reg,   out_valid_next;
    logic [31:0]        out_lba_reg,     out_lba_next;
    logic [11:0]        out_cluster_reg, out_cluster_next;
    logic               out_end_reg,     out_end_next;

    logic [7:0]         spc_reg;
    logic [31:0]        data_start_reg;

    logic               in_fire;
    action_t            act;
    logic [12:0]        in_index;
    logic [7:0]         in_byte;
    logic [11:0]        in_first;
    logic [31:0]        in_root;
    logic [7:0]         eff_spc;
    logic [7:0]         sic_inc;
    logic               wrap;
    logic               lookup_start;
    logic [11:0]        entry;
    logic signed [12:0] cluster_off;
    fcc_wr_t            wr;

    assign act      = action_t'(s_tuser);
    assign in_index = s_tdata[12:0];
    assign in_byte  = s_tdata[20:13];
    assign in_first = s_tdata[32:21];
    assign in_root  = s_tdata[64:33];

    assign s_tready = (state_reg == S_IDLE);
    assign in_fire  = s_tvalid && s_tready;

    assign eff_spc = (spc_reg > MAX_SPC) ? MAX_SPC : spc_reg;
    assign sic_inc = {1'b0, sic_reg} + 8'd1;
    assign wrap    = (sic_inc >= eff_spc);

    // The table is read with the current cluster in the accept cycle, so the
    // next cluster is ready in S_LOOKUP. Loads and lookups never share a cycle.
    assign lookup_start = in_fire && (act == ACT_ADVANCE) && !root_mode_reg
                          && !ended_reg && wrap;

    assign wr.en    = in_fire && (act == ACT_LOAD) && (32'(in_index) < TABLE_BYTES);
    assign wr.index = in_index;
    assign wr.data  = in_byte;

    fcc_fat_table #(
        .TABLE_BYTES (TABLE_BYTES)
    ) u_fat_table (
        .clk        (clk),
        .wr         (wr),
        .rd_en      (lookup_start),
        .rd_cluster (cluster_reg),
        .entry      (entry)
    );

    assign cluster_off = $signed({1'b0, cluster_reg} - FIRST_DATA_CLUSTER);

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spc_reg        <= SPC_RESET;
            data_start_reg <= DATA_START_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SPC:        spc_reg        <= cfg_data[7:0];
                CFG_DATA_START: data_start_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        cluster_next     = cluster_reg;
        sic_next         = sic_reg;
        root_block_next  = root_block_reg;
        root_mode_next   = root_mode_reg;
        ended_next       = ended_reg;
        product_next     = product_reg;
        base_next        = base_reg;
        out_valid_next   = out_valid_reg;
        out_lba_next     = out_lba_reg;
        out_cluster_next = out_cluster_reg;
        out_end_next     = out_end_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (act)
                        ACT_LOAD:
                        begin
                        end
                        ACT_OPEN_CHAIN:
                        begin
                            root_mode_next = 1'b0;
                            cluster_next   = in_first;
                            sic_next       = 7'd0;
                            ended_next     = (in_first >= END_MARK);
                        end
                        ACT_OPEN_ROOT:
                        begin
                            root_mode_next  = 1'b1;
                            root_block_next = in_root;
                            ended_next      = 1'b0;
                        end
                        ACT_ADVANCE:
                        begin
                            if (root_mode_reg)
                            begin
                                root_block_next = root_block_reg + 32'd1;
                            end
                            else if (!ended_reg)
                            begin
                                sic_next = wrap ? 7'd0 : sic_inc[6:0];
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    state_next = lookup_start ? S_LOOKUP : S_SCALE;
                end
            end
            S_LOOKUP:
            begin
                cluster_next = entry;
                if (entry >= END_MARK)
                begin
                    ended_next = 1'b1;
                end
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                product_next = cluster_off * $signed({1'b0, eff_spc});
                base_next    = data_start_reg + 32'(sic_reg);
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    if (root_mode_reg)
                    begin
                        out_lba_next = root_block_reg;
                    end
                    else if (ended_reg)
                    begin
                        out_lba_next = 32'd0;
                    end
                    else
                    begin
                        out_lba_next = base_reg + {{10{product_reg[21]}}, product_reg};
                    end
                    out_cluster_next = root_mode_reg ? 12'd0 : cluster_reg;
                    out_end_next     = ended_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cluster_reg    <= 12'd0;
            sic_reg        <= 7'd0;
            root_block_reg <= 32'd0;
            root_mode_reg  <= 1'b0;
            ended_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cluster_reg    <= cluster_next;
            sic_reg        <= sic_next;
            root_block_reg <= root_block_next;
            root_mode_reg  <= root_mode_next;
            ended_reg      <= ended_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        product_reg     <= product_next;
        base_reg        <= base_next;
        out_lba_reg     <= out_lba_next;
        out_cluster_reg <= out_cluster_next;
        out_end_reg     <= out_end_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_cluster_reg, out_lba_reg};
    assign m_tuser  = out_end_reg;

    // Root mode and a finished chain exclude each other.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(root_mode_reg && ended_reg))
    else $error("end of chain flagged while in root mode");

    // A table lookup is only ever entered straight from an accepted advance.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOKUP) |-> ($past(state_reg) == S_IDLE))
    else $error("table lookup entered without an accepted item");

    // An accepted item closes the input until its result is registered.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
    else $error("second item accepted while one is in flight");

    // A result flagged as end of chain carries a zero address.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_end_reg) |-> (out_lba_reg == 32'd0))
    else $error("end of chain reported with a nonzero address");

endmodule

`default_nettype wire

/* src/fcc_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module fcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* src/fcc_fat_table.sv */
// ----------------------------------------------------------------------------
// FAT12 allocation table store
// Byte table split into even and odd banks so that both bytes of a 12-bit
// entry are read together; the entry is valid in the cycle after rd_en.
// ----------------------------------------------------------------------------
`default_nettype none

module fcc_fat_table
    import fcc_pkg::*;
#(
    parameter int TABLE_BYTES = TABLE_BYTES_DEF
) (
    input  logic        clk,
    input  fcc_wr_t     wr,
    input  logic        rd_en,
    input  logic [11:0] rd_cluster,
    output logic [11:0] entry
);

    localparam int BANK_DEPTH = TABLE_BYTES / 2;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);

    logic [13:0]        lo_idx;
    logic [13:0]        hi_idx;
    logic [BANK_AW-1:0] even_raddr;
    logic [BANK_AW-1:0] odd_raddr;
    logic               lo_ok;
    logic               hi_ok;
    logic               odd_reg;
    logic               lo_odd_reg;
    logic               lo_ok_reg;
    logic               hi_ok_reg;
    logic [7:0]         even_q;
    logic [7:0]         odd_q;
    logic [7:0]         lo_byte;
    logic [7:0]         hi_byte;
    logic [15:0]        word;

    // Entry byte offset is cluster * 3 / 2.
    assign lo_idx = {2'b00, rd_cluster} + {3'b000, rd_cluster[11:1]};
    assign hi_idx = lo_idx + 14'd1;

    // When the entry starts at an odd byte offset the low byte sits in the odd
    // bank and the high byte in the next even slot; otherwise the low byte is
    // in the even bank and the high byte in the odd slot beside it.
    assign even_raddr = lo_idx[0] ? hi_idx[1 +: BANK_AW] : lo_idx[1 +: BANK_AW];
    assign odd_raddr  = lo_idx[1 +: BANK_AW];

    assign lo_ok = 32'(lo_idx) < TABLE_BYTES;
    assign hi_ok = 32'(hi_idx) < TABLE_BYTES;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            odd_reg    <= rd_cluster[0];
            lo_odd_reg <= lo_idx[0];
            lo_ok_reg  <= lo_ok;
            hi_ok_reg  <= hi_ok;
        end
    end

    fcc_ram #(
        .WIDTH (8),
        .DEPTH (BANK_DEPTH)
    ) u_even_bank (
        .clk   (clk),
        .we    (wr.en && !wr.index[0]),
        .waddr (wr.index[1 +: BANK_AW]),
        .wdata (wr.data),
        .re    (rd_en),
        .raddr (even_raddr),
        .rdata (even_q)
    );

    fcc_ram #(
        .WIDTH (8),
        .DEPTH (BANK_DEPTH)
    ) u_odd_bank (
        .clk   (clk),
        .we    (wr.en && wr.index[0]),
        .waddr (wr.index[1 +: BANK_AW]),
        .wdata (wr.data),
        .re    (rd_en),
        .raddr (odd_raddr),
        .rdata (odd_q)
    );

    // Bytes past the end of the table read as zero.
    assign lo_byte = !lo_ok_reg ? 8'd0 : (lo_odd_reg ? odd_q : even_q);
    assign hi_byte = !hi_ok_reg ? 8'd0 : (lo_odd_reg ? even_q : odd_q);
    assign word    = {hi_byte, lo_byte};
    assign entry   = odd_reg ? word[15:4] : word[11:0];

endmodule

`default_nettype wire

/* dv/fat12_cluster_chain_sequencer_checker.sv */
// ----------------------------------------------------------------------------
// FAT12 cluster chain sequencer checker
// Watches the table, position and configuration channels of the sequencer,
// keeps its own copy of the allocation table and walk position, and compares
// every output beat field by field with the position it expects.
// ----------------------------------------------------------------------------
module fat12_cluster_chain_sequencer_checker
    import fcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,
    input  logic [1:0]  s_tuser,

    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic [0:0]  m_tuser,

    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,

    output int          mismatch_count,
    output int          outstanding
);

    typedef struct packed {
        logic [31:0] lba;
        logic [11:0] cluster;
        logic        eoc;
    } sector_pos_t;

    logic [7:0]  fat_image [TABLE_BYTES_DEF];
    logic [11:0] cur_cluster;
    logic [6:0]  cur_sector;
    logic [31:0] root_lba;
    logic        in_root;
    logic        chain_done;
    logic [7:0]  spc;
    logic [31:0] data_start;

    sector_pos_t expected_positions [$];

    function automatic logic [31:0] spc_used();
        return (spc > MAX_SPC) ? 32'(MAX_SPC) : 32'(spc);
    endfunction

    function automatic logic [7:0] fat_byte(input logic [31:0] at);
        return (at < TABLE_BYTES_DEF) ? fat_image[at[12:0]] : 8'd0;
    endfunction

    // Entries are packed little-endian, two per three bytes.
    function automatic logic [11:0] next_in_chain(input logic [11:0] c);
        logic [31:0] at;
        logic [15:0] word;
        at   = 32'(c) * 3 / 2;
        word = {fat_byte(at + 1), fat_byte(at)};
        return c[0] ? word[15:4] : word[11:0];
    endfunction

    task automatic walk_step(input action_t act, input logic [12:0] idx,
                             input logic [7:0] bval, input logic [11:0] first,
                             input logic [31:0] rstart);
        sector_pos_t res;
        logic [31:0] nxt;
        case (act)
            ACT_LOAD:
                fat_image[idx] = bval;
            ACT_OPEN_CHAIN:
            begin
                in_root     = 1'b0;
                cur_cluster = first;
                cur_sector  = '0;
                chain_done  = (first >= END_MARK);
            end
            ACT_OPEN_ROOT:
            begin
                in_root    = 1'b1;
                root_lba   = rstart;
                chain_done = 1'b0;
            end
            default:
            begin
                if (in_root)
                begin
                    root_lba = root_lba + 32'd1;
                end
                else if (!chain_done)
                begin
                    nxt = 32'(cur_sector) + 32'd1;
                    if (nxt >= spc_used())
                    begin
                        cur_sector  = '0;
                        cur_cluster = next_in_chain(cur_cluster);
                        chain_done  = (cur_cluster >= END_MARK);
                    end
                    else
                    begin
                        cur_sector = nxt[6:0];
                    end
                end
            end
        endcase

        if (in_root)
            res.lba = root_lba;
        else if (chain_done)
            res.lba = '0;
        else
            res.lba = data_start
                    + (32'(cur_cluster) - 32'(FIRST_DATA_CLUSTER)) * spc_used()
                    + 32'(cur_sector);
        res.eoc     = chain_done;
        res.cluster = in_root ? 12'd0 : cur_cluster;
        expected_positions.push_back(res);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sector_pos_t want;
        if (!rst_n)
        begin
            cur_cluster    = '0;
            cur_sector     = '0;
            root_lba       = '0;
            in_root        = 1'b0;
            chain_done     = 1'b0;
            spc            = SPC_RESET;
            data_start     = DATA_START_RESET;
            mismatch_count = 0;
            expected_positions.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index_t'(cfg_index) == CFG_SPC)
                    spc = cfg_data[7:0];
                else
                    data_start = cfg_data;
            end

            // Results are matched before the new beat is queued; the pipeline
            // never returns an item in the cycle it was taken.
            if (m_tvalid && m_tready)
            begin
                if (expected_positions.size() == 0)
                begin
                    $error("result beat with no expected position: lba %h cluster %h eoc %b",
                           m_tdata[31:0], m_tdata[43:32], m_tuser[0]);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_positions.pop_front();
                    if (m_tdata[31:0] !== want.lba)
                    begin
                        $error("sector_lba: expected %h, got %h", want.lba, m_tdata[31:0]);
                        mismatch_count++;
                    end
                    if (m_tdata[43:32] !== want.cluster)
                    begin
                        $error("cluster_now: expected %h, got %h",
                               want.cluster, m_tdata[43:32]);
                        mismatch_count++;
                    end
                    if (m_tuser[0] !== want.eoc)
                    begin
                        $error("end_of_chain: expected %b, got %b", want.eoc, m_tuser[0]);
                        mismatch_count++;
                    end
                end
            end

            if (s_tvalid && s_tready)
                walk_step(action_t'(s_tuser), s_tdata[12:0], s_tdata[20:13],
                          s_tdata[32:21], s_tdata[64:33]);

            outstanding <= expected_positions.size();
        end
    end

endmodule

/* dv/fat12_cluster_chain_sequencer_tb.sv */
// ----------------------------------------------------------------------------
// FAT12 cluster chain sequencer testbench
// Builds allocation tables and cluster chains, walks them and the root
// directory under several sector-per-cluster and data-start settings, with
// random gaps on both streams and long output stalls; the checker module
// predicts each beat and counts mismatches.
// ----------------------------------------------------------------------------
module fat12_cluster_chain_sequencer_tb;
    import fcc_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PHASE_ITEMS  = 110;
    localparam int LONG_HOLDOFF = 400;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [31:0] cfg_data;

    int mismatch_count;
    int outstanding;
    int cycles = 0;
    int items_sent = 0;
    bit sender_calm = 1'b0;

    // Table image and walk position, kept so that no advance ever looks up a table
    // byte that has not been loaded; set_entry also reads the image to keep nibbles.
    logic [7:0]  tbl [TABLE_BYTES_DEF];
    bit          written [TABLE_BYTES_DEF];
    logic [7:0]  spc_now = SPC_RESET;
    logic [11:0] walk_cluster = '0;
    int          walk_sector = 0;
    bit          walk_root = 1'b0;
    bit          walk_ended = 1'b0;

    fat12_cluster_chain_sequencer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    fat12_cluster_chain_sequencer_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int eff_spc();
        return (spc_now > MAX_SPC) ? int'(MAX_SPC) : int'(spc_now);
    endfunction

    function automatic logic [11:0] walk_next(input logic [11:0] c);
        int unsigned at;
        logic [15:0] word;
        at   = c * 3 / 2;
        word = {tbl[at + 1], tbl[at]};
        return c[0] ? word[15:4] : word[11:0];
    endfunction

    task automatic issue(input action_t act, input logic [12:0] idx, input logic [7:0] bval,
                         input logic [11:0] first, input logic [31:0] rstart);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, 11);
        if ($urandom_range(0, 39) == 0)
            sender_calm = !sender_calm;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {7'd0, rstart, first, bval, idx};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        items_sent++;

        case (act)
            ACT_LOAD:
            begin
                tbl[idx]     = bval;
                written[idx] = 1'b1;
            end
            ACT_OPEN_CHAIN:
            begin
                walk_root    = 1'b0;
                walk_cluster = first;
                walk_sector  = 0;
                walk_ended   = (first >= END_MARK);
            end
            ACT_OPEN_ROOT:
            begin
                walk_root  = 1'b1;
                walk_ended = 1'b0;
            end
            default:
            begin
                if (!walk_root && !walk_ended)
                begin
                    if (walk_sector + 1 >= eff_spc())
                    begin
                        walk_sector  = 0;
                        walk_cluster = walk_next(walk_cluster);
                        walk_ended   = (walk_cluster >= END_MARK);
                    end
                    else
                    begin
                        walk_sector++;
                    end
                end
            end
        endcase
    endtask

    task automatic load_byte(input logic [12:0] idx, input logic [7:0] bval);
        issue(ACT_LOAD, idx, bval, 12'($urandom), $urandom);
    endtask

    task automatic open_chain(input logic [11:0] c);
        issue(ACT_OPEN_CHAIN, 13'($urandom), 8'($urandom), c, $urandom);
    endtask

    task automatic open_root(input logic [31:0] lba);
        issue(ACT_OPEN_ROOT, 13'($urandom), 8'($urandom), 12'($urandom), lba);
    endtask

    // Loads any missing entry bytes with random values before an advance
    // that leaves the cluster.
    task automatic advance();
        int unsigned at;
        if (!walk_root && !walk_ended && walk_sector + 1 >= eff_spc())
        begin
            at = walk_cluster * 3 / 2;
            for (int k = 0; k < 2; k++)
                if (!written[at + k])
                    load_byte(13'(at + k), 8'($urandom));
        end
        issue(ACT_ADVANCE, 13'($urandom), 8'($urandom), 12'($urandom), $urandom);
    endtask

    // Writes the 12-bit entry of cluster c, keeping the neighbor's nibble.
    task automatic set_entry(input logic [11:0] c, input logic [11:0] v);
        int unsigned at;
        logic [7:0]  lo;
        logic [7:0]  hi;
        at = c * 3 / 2;
        lo = written[at] ? tbl[at] : 8'($urandom);
        hi = written[at + 1] ? tbl[at + 1] : 8'($urandom);
        if (c[0])
        begin
            lo[7:4] = v[3:0];
            hi      = v[11:4];
        end
        else
        begin
            lo      = v[7:0];
            hi[3:0] = v[11:8];
        end
        load_byte(13'(at), lo);
        load_byte(13'(at + 1), hi);
    endtask

    task automatic run_chain();
        logic [11:0] hops [6];
        int len;
        int reach;
        len = $urandom_range(1, 5);
        for (int k = 0; k < len; k++)
            hops[k] = 12'($urandom_range(0, 12'hFF7));
        for (int k = 0; k < len - 1; k++)
            set_entry(hops[k], hops[k + 1]);
        if ($urandom_range(0, 3) == 0)
            set_entry(hops[len - 1], hops[0]);
        else
            set_entry(hops[len - 1], 12'($urandom_range(END_MARK, 12'hFFF)));
        open_chain(hops[0]);
        reach = len * ((eff_spc() == 0) ? 1 : eff_spc()) + 2;
        if (reach > 40 && $urandom_range(0, 7) != 0)
            reach = 40;
        if (reach > 140)
            reach = 140;
        repeat ($urandom_range(0, reach)) advance();
    endtask

    task automatic run_root();
        if ($urandom_range(0, 3) == 0)
            open_root(32'hFFFF_FFFF - $urandom_range(0, 5));
        else
            open_root($urandom);
        repeat ($urandom_range(1, 10)) advance();
    endtask

    task automatic run_noise();
        case ($urandom_range(0, 5))
            0, 1: load_byte(13'($urandom), 8'($urandom));
            2:    open_chain(12'($urandom));
            3:    open_root($urandom);
            default: advance();
        endcase
    endtask

    // Walks that start on an end marker or wander through random table bytes.
    task automatic run_broken();
        if ($urandom_range(0, 1) == 0)
            open_chain(12'($urandom_range(END_MARK, 12'hFFF)));
        else
            open_chain(12'($urandom));
        repeat ($urandom_range(1, 4)) advance();
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t which, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= which;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (which == CFG_SPC)
            spc_now = val[7:0];
        @(posedge clk);
    endtask

    // Output side: random stalls per beat, with two long hold-offs that
    // back the pipeline up into the input.
    initial
    begin
        int stall;
        int beats;
        bit calm;
        m_tready = 1'b0;
        beats    = 0;
        calm     = 1'b0;
        while (!rst_n) @(posedge clk);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 11);
            if ($urandom_range(0, 39) == 0)
                calm = !calm;
            if (beats == 150 || beats == 600)
                stall = LONG_HOLDOFF;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            beats++;
        end
    end

    initial
    begin
        logic [7:0]  spc_v;
        logic [31:0] ds_v;
        int          phase_end;
        int          pick;

        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = ACT_LOAD;
        cfg_valid = 1'b0;
        cfg_index = CFG_SPC;
        cfg_data  = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed walk under the reset configuration.
        load_byte(13'h1FFF, 8'hFF);
        load_byte(13'h0000, 8'h00);
        set_entry(12'd2, 12'd3);
        set_entry(12'd3, 12'hFFF);
        open_chain(12'd2);
        advance();
        advance();
        advance();
        open_chain(END_MARK);
        advance();
        open_root(32'hFFFF_FFFF);
        advance();
        load_byte(13'h1000, 8'h5A);
        advance();
        open_chain(12'd0);
        advance();
        open_chain(12'hFFF);

        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0:       begin spc_v = 8'd1;   ds_v = 32'd0;        end
                1:       begin spc_v = 8'd128; ds_v = 32'hFFFF_FFFF; end
                2:       begin spc_v = 8'd0;   ds_v = $urandom;     end
                3:       begin spc_v = 8'd255; ds_v = $urandom;     end
                4:       begin spc_v = 8'd2;   ds_v = 32'hFFFF_FF00; end
                5:       begin spc_v = 8'($urandom_range(1, 8)); ds_v = $urandom; end
                6:       begin spc_v = 8'($urandom_range(129, 254)); ds_v = 32'd0; end
                default: begin spc_v = 8'd3;   ds_v = $urandom;     end
            endcase
            settle();
            write_reg(CFG_SPC, 32'(spc_v));
            write_reg(CFG_DATA_START, ds_v);

            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    run_chain();
                else if (pick < 75)
                    run_root();
                else if (pick < 90)
                    run_noise();
                else
                    run_broken();
            end
        end

        settle();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
